[rtl/rfcc_pkg.sv]
package rfcc_pkg;

  localparam int unsigned LEN_W  = 9;
  localparam int unsigned CRC_W  = 16;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [8:0]  MIN_LEN_RESET = 9'd6;
  localparam logic [8:0]  MAX_LEN_RESET = 9'd95;
  localparam logic [8:0]  LEN_FLOOR = 9'd2;

  localparam logic REG_MIN_LEN = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LEN_ERR = 2'd1,
    ST_CRC_ERR = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } word_t;

  typedef struct packed {
    logic  valid;
    word_t word;
  } queue_head_t;

  typedef struct packed {
    logic [LEN_W-1:0] min_length;
    logic [LEN_W-1:0] max_length;
  } cfg_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/rfcc_front.sv]
module rfcc_front import rfcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output queue_head_t head_o,
  input  logic        pop_i
);

  word_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{data_byte: data_byte_i, last_byte: last_byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.word  = mem_q[rd_ptr_q];

endmodule

[rtl/rfcc_back.sv]
module rfcc_back import rfcc_pkg::*; #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  queue_head_t      head_i,
  output logic             pop_o,
  input  cfg_t             cfg_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       frame_status_o,
  output logic [LEN_W-1:0] frame_length_o,
  output logic [CRC_W-1:0] computed_crc_o
);

  localparam logic [LEN_W-1:0] CntSat = LEN_W'(MAX_FRAME + 1);

  logic [15:0]      crc_q, crc_d;
  logic [7:0]       held0_q, held0_d;
  logic [7:0]       held1_q, held1_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic [LEN_W-1:0] len_q;
  logic [15:0]      crc_out_q;

  logic [15:0]      crc_upd;
  logic [LEN_W-1:0] cnt_inc;
  logic             finish;

  assign pop_o  = head_i.valid && (!head_i.word.last_byte || !out_valid_q || out_ready_i);
  assign finish = pop_o && head_i.word.last_byte;

  always_comb begin
    crc_upd = (cnt_q >= LEN_FLOOR) ? crc16_byte(crc_q, held0_q) : crc_q;
    cnt_inc = (cnt_q < CntSat) ? cnt_q + LEN_W'(1) : cnt_q;

    if (cnt_inc < LEN_FLOOR || cnt_inc < cfg_i.min_length || cnt_inc > cfg_i.max_length) begin
      status_d = ST_LEN_ERR;
    end else if (held1_q == crc_upd[7:0] && head_i.word.data_byte == crc_upd[15:8]) begin
      status_d = ST_OK;
    end else begin
      status_d = ST_CRC_ERR;
    end

    crc_d   = crc_q;
    held0_d = held0_q;
    held1_d = held1_q;
    cnt_d   = cnt_q;
    if (finish) begin
      crc_d   = CRC_PRESET;
      held0_d = 8'h00;
      held1_d = 8'h00;
      cnt_d   = '0;
    end else if (pop_o) begin
      crc_d   = crc_upd;
      held0_d = held1_q;
      held1_d = head_i.word.data_byte;
      cnt_d   = cnt_inc;
    end

    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_PRESET;
      held0_q     <= 8'h00;
      held1_q     <= 8'h00;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      held0_q     <= held0_d;
      held1_q     <= held1_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_q  <= status_d;
      len_q     <= cnt_inc;
      crc_out_q <= crc_upd;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;
  assign frame_length_o = len_q;
  assign computed_crc_o = crc_out_q;

endmodule

[rtl/rtu_frame_crc_checker_core.sv]
// Modbus RTU frame checker.
// Input channel (in_valid_i/in_ready_o): one frame byte per word, with
// last_byte_i set on the final byte. Output channel (out_valid_o/out_ready_i):
// one verdict word per frame, carrying status (ok, length error, CRC error),
// the byte count (saturating at MAX_FRAME + 1) and the CRC over all bytes
// but the last two. The CRC bytes must arrive low byte first.
// Throughput: one byte per cycle, set by the byte-wide CRC update, except that
// a final byte waits while a verdict is pending. A last byte passes through the
// queue; when it is popped, its verdict is registered in the output register.
// A two-word queue sits between input and CRC engine; when the receiver
// stalls, non-final bytes keep flowing into the engine, and a final byte
// waits in the queue until the pending verdict is taken; meanwhile the next
// byte fills the queue and in_ready_o drops.
// Configuration: cfg_we_i writes min_length (index 0) or max_length (index 1)
// from cfg_wdata_i; write only while idle.
// Reset: clears the frame state (CRC preset 0xFFFF, count zero), empties the
// queue and output, and sets min_length to 6 and max_length to 95.
module rtu_frame_crc_checker_core import rfcc_pkg::*; #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       frame_status_o,
  output logic [LEN_W-1:0] frame_length_o,
  output logic [CRC_W-1:0] computed_crc_o
);

  cfg_t        cfg_q, cfg_d;
  queue_head_t head;
  logic        pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_LEN: cfg_d.min_length = cfg_wdata_i;
        REG_MAX_LEN: cfg_d.max_length = cfg_wdata_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_length <= MIN_LEN_RESET;
      cfg_q.max_length <= MAX_LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rfcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .head_o      (head),
    .pop_i       (pop)
  );

  rfcc_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .cfg_i          (cfg_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_status_o (frame_status_o),
    .frame_length_o (frame_length_o),
    .computed_crc_o (computed_crc_o)
  );

endmodule
